@@ rtl/msd_pkg.sv @@
// shared constants, types and rounding for the matrix surround decoder
`default_nettype none

package msd_pkg;

  // filter and delay geometry (delay depth is a power of two)
  localparam int TAPS        = 32;
  localparam int DELAY_DEPTH = 4096;

  localparam int TAPS_W  = $clog2(TAPS);
  localparam int DLY_W   = $clog2(DELAY_DEPTH);
  localparam int FILL_W  = DLY_W + 1;
  localparam int CNT_W   = $clog2(TAPS + 3);
  localparam int ACC_W   = 32 + TAPS_W;

  // configuration register
  localparam int          DREG_W    = 12;
  localparam int          ADDR_W    = 3;
  localparam logic [DREG_W-1:0] DLY_RST = DREG_W'(960);
  localparam logic        REG_DELAY = 1'b0;

  // item kinds
  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_COEF   = 1'b1;

  // Q1.15 matrix constants
  localparam logic signed [15:0] K_FRONT = 16'sd23167;
  localparam logic signed [15:0] K_BIG   = 16'sd19261;
  localparam logic signed [15:0] K_SMALL = 16'sd12871;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_WRITE,
    ST_READ,
    ST_LOAD
  } st_t;

  // what a multiply slot computes
  typedef enum logic [1:0] {
    OP_FIR,
    OP_FRONT,
    OP_MIX_A,
    OP_MIX_B
  } op_t;

  // Q2.30 to Q1.15: round half up, then saturate
  function automatic logic signed [15:0] round_sat(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] t;
    logic signed [ACC_W-1:0] q;
    logic signed [ACC_W-1:0] smax;
    logic signed [ACC_W-1:0] smin;
    t    = a + ACC_W'(16384);
    q    = t >>> 15;
    smax = ACC_W'(32767);
    smin = -ACC_W'(32768);
    if (q > smax) begin
      round_sat = 16'sh7fff;
    end else if (q < smin) begin
      round_sat = 16'sh8000;
    end else begin
      round_sat = q[15:0];
    end
  endfunction

endpackage

`default_nettype wire

@@ rtl/matrix_surround_decoder.sv @@
// matrix surround decoder top level: sequencer, memories, shared mac pair
//
//  channel  | signals                                          | direction
//  ---------+--------------------------------------------------+----------
//  input    | in_valid/in_ready, func, stereo pair, coef write | in
//  result   | out_valid/out_ready, front and rear pairs        | out
//  config   | psel/penable/pwrite/paddr/pwdata/prdata/pready   | in/out
//
// a sample transaction runs TAPS+3 mac slots over the mix-queue and coefficient
// memories, drains the mac pipeline, then does writeback, delay read and load; the
// next is taken in the cycle after the load.
// a coefficient transaction is written while idle. reset and a delay write leave the
// delay memory dirty; a fill count makes unwritten entries read as zero.
// a stalled result holds the output register; the next sample waits at its load.
`default_nettype none

module matrix_surround_decoder import msd_pkg::*; (
  input  wire                      clk,
  input  wire                      rst_n,
  // input channel
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire                      in_func,
  input  wire  signed [15:0]       in_left_in,
  input  wire  signed [15:0]       in_right_in,
  input  wire         [4:0]        in_coef_index,
  input  wire  signed [15:0]       in_coef_value,
  // result channel
  output logic                     out_valid,
  input  wire                      out_ready,
  output logic signed [15:0]       out_front_left,
  output logic signed [15:0]       out_front_right,
  output logic signed [15:0]       out_rear_left,
  output logic signed [15:0]       out_rear_right,
  // configuration port
  input  wire                      psel,
  input  wire                      penable,
  input  wire                      pwrite,
  input  wire         [ADDR_W-1:0] paddr,
  input  wire         [31:0]       pwdata,
  output logic        [31:0]       prdata,
  output logic                     pready
);

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TAPS + 2);

  // control state
  st_t                 state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r;
  logic [TAPS_W-1:0]   qpos_r;
  logic [DLY_W-1:0]    rd_r;
  logic [FILL_W-1:0]   fill_r;
  logic [DREG_W-1:0]   dly_r;
  logic [TAPS-1:0]     coef_vld_r;
  logic [TAPS-1:0]     mix_vld_r;
  logic                vld_b_r, vld_c_r;
  logic                out_valid_r;

  // payload state
  op_t                 op_b_r, op_c_r;
  logic signed [15:0]  l_r, r_r;
  logic signed [15:0]  coef_q_r;
  logic                coef_qv_r;
  logic [31:0]         mix_q_r;
  logic                mix_qv_r;
  logic signed [31:0]  prod_l_r, prod_r_r;
  logic signed [ACC_W-1:0] acc_l_r, acc_r_r;
  logic signed [ACC_W-1:0] mix_l_r, mix_r_r;
  logic signed [31:0]  fr_l_r, fr_r_r;
  logic [31:0]         dly_q_r;
  logic signed [15:0]  ofl_r, ofr_r, orl_r, orr_r;

  // memories
  logic signed [15:0]  coef_mem [TAPS];
  logic [31:0]         mix_mem  [TAPS];
  logic [31:0]         dly_mem  [DELAY_DEPTH];

  // decoded controls
  logic                smp_acc, coef_we, issue, wb, dly_re, out_load, cfg_wr;
  op_t                 op_iss;
  logic [TAPS_W-1:0]   mix_raddr;
  logic [TAPS_W:0]     mix_sum;
  logic [DLY_W-1:0]    d_eff, wpos;
  logic [DLY_W:0]      wsum;
  logic signed [15:0]  mul_al, mul_bl, mul_ar, mul_br;
  logic signed [15:0]  coef_m, mixl_m, mixr_m;
  logic signed [15:0]  rnd_l, rnd_r, mixl_rnd, mixr_rnd;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_DELAY);
  assign prdata = (paddr[2] == REG_DELAY) ? {{(32-DREG_W){1'b0}}, dly_r} : 32'd0;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid && in_func == FUNC_SAMPLE) state_nxt = ST_RUN;
      ST_RUN:   if (cnt_r == CNT_LAST) state_nxt = ST_DRAIN;
      ST_DRAIN: if (!vld_b_r && !vld_c_r) state_nxt = ST_WRITE;
      ST_WRITE: state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_LOAD;
      ST_LOAD:  if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    issue    = 1'b0;
    wb       = 1'b0;
    dly_re   = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      ST_IDLE:  in_ready = 1'b1;
      ST_RUN:   issue    = 1'b1;
      ST_DRAIN: ;
      ST_WRITE: wb       = 1'b1;
      ST_READ:  dly_re   = 1'b1;
      ST_LOAD:  out_load = !out_valid_r || out_ready;
      default:  ;
    endcase
  end

  assign smp_acc = in_valid && in_ready && (in_func == FUNC_SAMPLE);
  assign coef_we = in_valid && in_ready && (in_func == FUNC_COEF) &&
                   (32'(in_coef_index) < TAPS);

  // slot kind for the current issue count
  always_comb begin
    if (cnt_r < CNT_W'(TAPS)) begin
      op_iss = OP_FIR;
    end else if (cnt_r == CNT_W'(TAPS)) begin
      op_iss = OP_FRONT;
    end else if (cnt_r == CNT_W'(TAPS + 1)) begin
      op_iss = OP_MIX_A;
    end else begin
      op_iss = OP_MIX_B;
    end
  end

  // queue slot for tap k, wrapped once
  assign mix_sum   = {1'b0, qpos_r} + {1'b0, cnt_r[TAPS_W-1:0]};
  assign mix_raddr = (mix_sum >= (TAPS_W+1)'(TAPS)) ?
                     TAPS_W'(mix_sum - (TAPS_W+1)'(TAPS)) : mix_sum[TAPS_W-1:0];

  // delay write position
  assign d_eff = DLY_W'(dly_r);
  assign wsum  = {1'b0, rd_r} + {1'b0, d_eff};
  assign wpos  = (wsum >= (DLY_W+1)'(DELAY_DEPTH)) ?
                 DLY_W'(wsum - (DLY_W+1)'(DELAY_DEPTH)) : wsum[DLY_W-1:0];

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      qpos_r      <= '0;
      rd_r        <= '0;
      fill_r      <= '0;
      dly_r       <= DLY_RST;
      coef_vld_r  <= '0;
      mix_vld_r   <= '0;
      vld_b_r     <= 1'b0;
      vld_c_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      vld_b_r <= issue;
      vld_c_r <= vld_b_r;
      if (smp_acc) begin
        cnt_r <= '0;
      end else if (issue) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (coef_we) begin
        coef_vld_r[TAPS_W'(in_coef_index)] <= 1'b1;
      end
      if (wb) begin
        mix_vld_r[qpos_r] <= 1'b1;
      end
      if (out_load) begin
        qpos_r <= (qpos_r == '0) ? TAPS_W'(TAPS - 1) : qpos_r - TAPS_W'(1);
        rd_r   <= (rd_r == DLY_W'(DELAY_DEPTH - 1)) ? '0 : rd_r + DLY_W'(1);
        if (fill_r != FILL_W'(DELAY_DEPTH)) begin
          fill_r <= fill_r + FILL_W'(1);
        end
      end
      // delay write empties the delay memory by clearing the fill count and read position
      if (cfg_wr) begin
        dly_r  <= pwdata[DREG_W-1:0];
        rd_r   <= '0;
        fill_r <= '0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // coefficient memory
  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[TAPS_W'(in_coef_index)] <= in_coef_value;
    end
    if (issue) begin
      coef_q_r  <= coef_mem[cnt_r[TAPS_W-1:0]];
      coef_qv_r <= coef_vld_r[cnt_r[TAPS_W-1:0]];
    end
  end

  // mix queue memory, left in the upper half
  always_ff @(posedge clk) begin
    if (wb) begin
      mix_mem[qpos_r] <= {mixl_rnd, mixr_rnd};
    end
    if (issue) begin
      mix_q_r  <= mix_mem[mix_raddr];
      mix_qv_r <= mix_vld_r[mix_raddr];
    end
  end

  // delay memory, left in the upper half
  always_ff @(posedge clk) begin
    if (wb) begin
      dly_mem[wpos] <= {rnd_l, rnd_r};
    end
    if (dly_re) begin
      dly_q_r <= dly_mem[rd_r];
    end
  end

  // operand select for the multiplier pair
  assign coef_m = coef_qv_r ? coef_q_r : 16'sd0;
  assign mixl_m = mix_qv_r ? signed'(mix_q_r[31:16]) : 16'sd0;
  assign mixr_m = mix_qv_r ? signed'(mix_q_r[15:0])  : 16'sd0;

  always_comb begin
    case (op_b_r)
      OP_FIR: begin
        mul_al = coef_m; mul_bl = mixl_m;
        mul_ar = coef_m; mul_br = mixr_m;
      end
      OP_FRONT: begin
        mul_al = l_r; mul_bl = K_FRONT;
        mul_ar = r_r; mul_br = K_FRONT;
      end
      OP_MIX_A: begin
        mul_al = l_r; mul_bl = K_SMALL;
        mul_ar = l_r; mul_br = K_BIG;
      end
      default: begin
        mul_al = r_r; mul_bl = -K_BIG;
        mul_ar = r_r; mul_br = -K_SMALL;
      end
    endcase
  end

  // multiply stage and accumulate stage
  always_ff @(posedge clk) begin
    if (smp_acc) begin
      l_r     <= in_left_in;
      r_r     <= in_right_in;
      acc_l_r <= '0;
      acc_r_r <= '0;
    end
    if (issue) begin
      op_b_r <= op_iss;
    end
    prod_l_r <= mul_al * mul_bl;
    prod_r_r <= mul_ar * mul_br;
    op_c_r   <= op_b_r;
    if (vld_c_r) begin
      case (op_c_r)
        OP_FIR: begin
          acc_l_r <= acc_l_r + ACC_W'(prod_l_r);
          acc_r_r <= acc_r_r + ACC_W'(prod_r_r);
        end
        OP_FRONT: begin
          fr_l_r <= prod_l_r;
          fr_r_r <= prod_r_r;
        end
        OP_MIX_A: begin
          mix_l_r <= ACC_W'(prod_l_r);
          mix_r_r <= ACC_W'(prod_r_r);
        end
        default: begin
          mix_l_r <= mix_l_r + ACC_W'(prod_l_r);
          mix_r_r <= mix_r_r + ACC_W'(prod_r_r);
        end
      endcase
    end
  end

  // rounding for writeback
  assign rnd_l    = round_sat(acc_l_r);
  assign rnd_r    = round_sat(acc_r_r);
  assign mixl_rnd = round_sat(mix_l_r);
  assign mixr_rnd = round_sat(mix_r_r);

  // output register; unwritten delay entries read as zero
  always_ff @(posedge clk) begin
    if (out_load) begin
      ofl_r <= round_sat(ACC_W'(fr_l_r));
      ofr_r <= round_sat(ACC_W'(fr_r_r));
      if (fill_r >= FILL_W'(d_eff)) begin
        orl_r <= signed'(dly_q_r[31:16]);
        orr_r <= signed'(dly_q_r[15:0]);
      end else begin
        orl_r <= 16'sd0;
        orr_r <= 16'sd0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_front_left  = ofl_r;
  assign out_front_right = ofr_r;
  assign out_rear_left   = orl_r;
  assign out_rear_right  = orr_r;

`ifndef SYNTHESIS
  // pipeline is empty before writeback
  a_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WRITE) |-> (!vld_b_r && !vld_c_r))
    else $error("mac pipeline busy at writeback");

  // fill count never passes the memory depth
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(DELAY_DEPTH))
    else $error("fill count overflow");

  // queue position stays within the taps
  a_qpos: assert property (@(posedge clk) disable iff (!rst_n)
    32'(qpos_r) < TAPS)
    else $error("queue position out of range");

  // a finished sample always presents a result
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("result lost at load");
`endif

endmodule

`default_nettype wire
